>>> sv/rc6enc_pkg.sv
// rc6enc_pkg: shared types, codes and constants for the rc6 biphase pulse encoder
// holds payload structs, microcode control word layout and step addresses
// no dependencies
package rc6enc_pkg;

	// operation codes of an input word
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PUSH   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_UNIT_TIME       = 2'd0;
	localparam logic [1:0] REG_LEAD_PULSE_TIME = 2'd1;
	localparam logic [1:0] REG_LEAD_SPACE_TIME = 2'd2;

	localparam logic [11:0] UNIT_TIME_RST       = 12'd444;
	localparam logic [13:0] LEAD_PULSE_TIME_RST = 14'd2666;
	localparam logic [13:0] LEAD_SPACE_TIME_RST = 14'd888;

	localparam int MAX_BITS_DEF = 16;
	localparam int CFG_W        = 14;
	localparam int CFG_IDX_W    = 2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] word_bits;
		logic [4:0]  bit_count;
	} in_t;

	typedef struct packed {
		logic        level;
		logic [13:0] duration;
		logic        last;
	} out_t;

	// microcode field types
	typedef logic [4:0] step_t;
	typedef logic [2:0] lvl_sel_t;
	typedef logic [2:0] dur_sel_t;
	typedef logic [1:0] last_sel_t;
	typedef logic [1:0] hold_op_t;
	typedef logic [2:0] br_t;

	localparam lvl_sel_t LVL_ONE  = 3'd0;
	localparam lvl_sel_t LVL_ZERO = 3'd1;
	localparam lvl_sel_t LVL_BIT  = 3'd2;
	localparam lvl_sel_t LVL_NBIT = 3'd3;
	localparam lvl_sel_t LVL_HELD = 3'd4;

	localparam dur_sel_t DUR_LEAD_P   = 3'd0;
	localparam dur_sel_t DUR_LEAD_S   = 3'd1;
	localparam dur_sel_t DUR_UNIT     = 3'd2;
	localparam dur_sel_t DUR_TWO_UNIT = 3'd3;
	localparam dur_sel_t DUR_HELD     = 3'd4;
	localparam dur_sel_t DUR_HELD_U   = 3'd5;

	localparam last_sel_t LAST_NO       = 2'd0;
	localparam last_sel_t LAST_YES      = 2'd1;
	localparam last_sel_t LAST_ONE_LEFT = 2'd2;

	localparam hold_op_t HOLD_KEEP   = 2'd0;
	localparam hold_op_t HOLD_HEADER = 2'd1;
	localparam hold_op_t HOLD_BIT    = 2'd2;
	localparam hold_op_t HOLD_CLEAR  = 2'd3;

	localparam br_t BR_NEXT     = 3'd0;
	localparam br_t BR_ALWAYS   = 3'd1;
	localparam br_t BR_CNT_ZERO = 3'd2;
	localparam br_t BR_NOT_SAME = 3'd3;
	localparam br_t BR_NO_HOLD  = 3'd4;
	localparam br_t BR_DONE     = 3'd5;

	// program entry points and jump targets
	localparam step_t ST_START    = 5'd0;
	localparam step_t ST_PUSH     = 5'd10;
	localparam step_t ST_P_SPLIT  = 5'd13;
	localparam step_t ST_P_SECOND = 5'd15;
	localparam step_t ST_END      = 5'd16;
	localparam step_t ST_FINISH   = 5'd17;

	typedef struct packed {
		logic      emit;
		lvl_sel_t  lvl_sel;
		dur_sel_t  dur_sel;
		last_sel_t last_sel;
		hold_op_t  hold_op;
		logic      dec;
		br_t       br;
		step_t     target;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic slot_free;
		logic cnt_zero;
		logic same;
		logic no_hold;
		logic held_pulse;
		logic held_space;
	} stat_t;

endpackage

>>> sv/rc6_biphase_pulse_encoder_top.sv
// rc6_biphase_pulse_encoder_top: rc6 mode-6 biphase encoder producing pulse/space words
// depends on rc6enc_pkg, rc6enc_urom, rc6enc_seq, rc6enc_dp
//
// Usage: an input word carries an operation. start sends the frame header (lead
// pulse and space, start bit, mode bits, double-width trailer) as ten output
// words and keeps the trailer's last pulse in a one-segment hold. push sends the
// low bit_count bits of word_bits, msb first, as biphase halves; a half of the
// same level as the hold merges into it. finish flushes the hold. The final
// output word of each input word has last set; words that cause nothing
// (bit count zero, empty hold, unused code) give no output.
// Timing: the block takes one input word at a time; in_ready is low until its
// program ends. A small microcode program runs one control word per cycle
// while the output register has room, so the step counter sets the rate.
// Start emits from its first step; finish first tests the hold, and push first
// tests the bit count and the held level. A stalled receiver holds the output
// register and the step counter waits on the emitting step; nothing is dropped.
// Reset clears the hold, the control state and the output valid, and loads the
// default times 444, 2666 and 888 us; config writes act at once, so make them
// only while idle.
module rc6_biphase_pulse_encoder_top #(
	parameter int MAX_BITS = rc6enc_pkg::MAX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rc6enc_pkg::in_t                  in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rc6enc_pkg::out_t                 out_data,
	input  logic                             cfg_we,
	input  logic [rc6enc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rc6enc_pkg::CFG_W-1:0]     cfg_data
);
	import rc6enc_pkg::*;

	step_t step;
	ctrl_t ctrl;
	stat_t stat;
	logic  take;
	logic  busy;
	logic  load;

	assign load = in_valid && in_ready;

	rc6enc_urom u_urom (
		.step (step),
		.ctrl (ctrl)
	);

	rc6enc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (in_data.operation),
		.ctrl      (ctrl),
		.stat      (stat),
		.step      (step),
		.take      (take),
		.busy      (busy)
	);

	rc6enc_dp #(
		.MAX_BITS (MAX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load      (load),
		.in_data   (in_data),
		.ctrl      (ctrl),
		.take      (take),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// an emitting step blocked by a full output register stays put
	a_stall_holds_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && ctrl.emit && out_valid && !out_ready) |=> (busy && $stable(step)))
		else $error("step advanced while output stalled");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer not busy after accepting a word");

	a_hold_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.held_pulse && stat.held_space))
		else $error("hold marked as pulse and space at once");

	a_out_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy))
		else $error("output word appeared with no program running");

endmodule

>>> sv/rc6enc_urom.sv
// rc6enc_urom: microcode program of the rc6 encoder, one control word per step
// depends on rc6enc_pkg
module rc6enc_urom (
	input  rc6enc_pkg::step_t step,
	output rc6enc_pkg::ctrl_t ctrl
);
	import rc6enc_pkg::*;

	function automatic ctrl_t cw(logic e, lvl_sel_t l, dur_sel_t d, last_sel_t ls,
			hold_op_t h, logic dc, br_t b, step_t t);
		ctrl_t c;
		c.emit     = e;
		c.lvl_sel  = l;
		c.dur_sel  = d;
		c.last_sel = ls;
		c.hold_op  = h;
		c.dec      = dc;
		c.br       = b;
		c.target   = t;
		return c;
	endfunction

	always_comb begin
		case (step)
			// header: lead, start bit 1, mode 110, double-width trailer 0
			5'd0: ctrl = cw(1'b1, LVL_ONE, DUR_LEAD_P, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd1: ctrl = cw(1'b1, LVL_ZERO, DUR_LEAD_S, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd2: ctrl = cw(1'b1, LVL_ONE, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd3: ctrl = cw(1'b1, LVL_ZERO, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd4: ctrl = cw(1'b1, LVL_ONE, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd5: ctrl = cw(1'b1, LVL_ZERO, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd6: ctrl = cw(1'b1, LVL_ONE, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd7: ctrl = cw(1'b1, LVL_ZERO, DUR_TWO_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT,
				ST_END);
			5'd8: ctrl = cw(1'b1, LVL_ONE, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd9: ctrl = cw(1'b1, LVL_ZERO, DUR_TWO_UNIT, LAST_YES, HOLD_HEADER, 1'b0, BR_DONE,
				ST_END);
			// push loop: one pass per bit
			5'd10: ctrl = cw(1'b0, LVL_BIT, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_CNT_ZERO,
				ST_END);
			5'd11: ctrl = cw(1'b0, LVL_BIT, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NOT_SAME,
				ST_P_SPLIT);
			// first half merges with the held segment
			5'd12: ctrl = cw(1'b1, LVL_BIT, DUR_HELD_U, LAST_ONE_LEFT, HOLD_BIT, 1'b1, BR_ALWAYS,
				ST_PUSH);
			5'd13: ctrl = cw(1'b0, LVL_BIT, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_NO_HOLD,
				ST_P_SECOND);
			// held segment has the other level: flush it first
			5'd14: ctrl = cw(1'b1, LVL_NBIT, DUR_HELD, LAST_NO, HOLD_KEEP, 1'b0, BR_NEXT, ST_END);
			5'd15: ctrl = cw(1'b1, LVL_BIT, DUR_UNIT, LAST_ONE_LEFT, HOLD_BIT, 1'b1, BR_ALWAYS,
				ST_PUSH);
			5'd16: ctrl = cw(1'b0, LVL_ZERO, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_DONE, ST_END);
			// finish: flush the hold if there is one
			5'd17: ctrl = cw(1'b0, LVL_HELD, DUR_HELD, LAST_NO, HOLD_KEEP, 1'b0, BR_NO_HOLD,
				ST_END);
			5'd18: ctrl = cw(1'b1, LVL_HELD, DUR_HELD, LAST_YES, HOLD_CLEAR, 1'b0, BR_DONE, ST_END);
			default: ctrl = cw(1'b0, LVL_ZERO, DUR_UNIT, LAST_NO, HOLD_KEEP, 1'b0, BR_DONE, ST_END);
		endcase
	end

endmodule

>>> sv/rc6enc_seq.sv
// rc6enc_seq: step counter with dispatch and conditional jumps
// depends on rc6enc_pkg; reads the control word from rc6enc_urom
module rc6enc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  rc6enc_pkg::ctrl_t ctrl,
	input  rc6enc_pkg::stat_t stat,
	output rc6enc_pkg::step_t step,
	output logic              take,
	output logic              busy
);
	import rc6enc_pkg::*;

	step_t step_q;
	logic  busy_q;
	step_t entry;
	logic  jump;

	always_comb begin
		case (operation)
			OP_START:  entry = ST_START;
			OP_PUSH:   entry = ST_PUSH;
			OP_FINISH: entry = ST_FINISH;
			default:   entry = ST_END;
		endcase
	end

	always_comb begin
		case (ctrl.br)
			BR_ALWAYS:   jump = 1'b1;
			BR_CNT_ZERO: jump = stat.cnt_zero;
			BR_NOT_SAME: jump = !stat.same;
			BR_NO_HOLD:  jump = stat.no_hold;
			default:     jump = 1'b0;
		endcase
	end

	// an emitting step waits for room in the output register
	assign take     = busy_q && (!ctrl.emit || stat.slot_free);
	assign in_ready = !busy_q;
	assign step     = step_q;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_END;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				step_q <= entry;
			end
		end else if (take) begin
			if (ctrl.br == BR_DONE) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + 5'd1;
			end
		end
	end

endmodule

>>> sv/rc6enc_dp.sv
// rc6enc_dp: datapath of the rc6 encoder: config registers, bit counter,
// one-segment hold, duration select and output register; depends on rc6enc_pkg
module rc6enc_dp #(
	parameter int MAX_BITS = rc6enc_pkg::MAX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rc6enc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rc6enc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                               load,
	input  rc6enc_pkg::in_t                    in_data,
	input  rc6enc_pkg::ctrl_t                  ctrl,
	input  logic                               take,
	output rc6enc_pkg::stat_t                  stat,
	output logic                               out_valid,
	input  logic                               out_ready,
	output rc6enc_pkg::out_t                   out_data
);
	import rc6enc_pkg::*;

	localparam int CW = $clog2(MAX_BITS + 1);
	localparam int IW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

	logic [11:0]         unit_q;
	logic [13:0]         lead_p_q;
	logic [13:0]         lead_s_q;
	logic [MAX_BITS-1:0] word_q;
	logic [CW-1:0]       cnt_q;
	logic [12:0]         held_time_q;
	logic                held_pulse_q;
	logic                held_space_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [5:0]          bc_ext;
	logic [CW-1:0]       cnt_load;
	logic [IW-1:0]       bit_idx;
	logic                cur_bit;
	logic                lvl;
	logic [13:0]         dur;
	logic                last_flag;
	logic                slot_free;
	logic                fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= UNIT_TIME_RST;
			lead_p_q <= LEAD_PULSE_TIME_RST;
			lead_s_q <= LEAD_SPACE_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNIT_TIME:       unit_q   <= cfg_data[11:0];
				REG_LEAD_PULSE_TIME: lead_p_q <= cfg_data;
				REG_LEAD_SPACE_TIME: lead_s_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bit count saturates at MAX_BITS
	assign bc_ext   = {1'b0, in_data.bit_count};
	assign cnt_load = (bc_ext > 6'(MAX_BITS)) ? CW'(MAX_BITS) : CW'(in_data.bit_count);

	assign bit_idx = IW'(cnt_q - 1'b1);
	assign cur_bit = (cnt_q != '0) ? word_q[bit_idx] : 1'b0;

	always_comb begin
		case (ctrl.lvl_sel)
			LVL_ONE:  lvl = 1'b1;
			LVL_BIT:  lvl = cur_bit;
			LVL_NBIT: lvl = !cur_bit;
			LVL_HELD: lvl = held_pulse_q;
			default:  lvl = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.dur_sel)
			DUR_LEAD_P:   dur = lead_p_q;
			DUR_LEAD_S:   dur = lead_s_q;
			DUR_TWO_UNIT: dur = {1'b0, unit_q, 1'b0};
			DUR_HELD:     dur = {1'b0, held_time_q};
			DUR_HELD_U:   dur = {1'b0, held_time_q} + {2'b00, unit_q};
			default:      dur = {2'b00, unit_q};
		endcase
	end

	always_comb begin
		case (ctrl.last_sel)
			LAST_YES:      last_flag = 1'b1;
			LAST_ONE_LEFT: last_flag = (cnt_q == CW'(1));
			default:       last_flag = 1'b0;
		endcase
	end

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = take && ctrl.emit;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= MAX_BITS'(in_data.word_bits);
			cnt_q  <= cnt_load;
		end else if (take && ctrl.dec) begin
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_time_q  <= '0;
			held_pulse_q <= 1'b0;
			held_space_q <= 1'b0;
		end else if (take) begin
			case (ctrl.hold_op)
				HOLD_HEADER: begin
					held_time_q  <= {unit_q, 1'b0};
					held_pulse_q <= 1'b1;
					held_space_q <= 1'b0;
				end
				// second half of the bit has the opposite level
				HOLD_BIT: begin
					held_time_q  <= {1'b0, unit_q};
					held_pulse_q <= !cur_bit;
					held_space_q <= cur_bit;
				end
				HOLD_CLEAR: begin
					held_time_q  <= '0;
					held_pulse_q <= 1'b0;
					held_space_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.level    <= lvl;
			out_q.duration <= dur;
			out_q.last     <= last_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.slot_free  = slot_free;
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.same       = cur_bit ? held_pulse_q : held_space_q;
	assign stat.no_hold    = !held_pulse_q && !held_space_q;
	assign stat.held_pulse = held_pulse_q;
	assign stat.held_space = held_space_q;

endmodule
